// ----- rtl/awm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package awm_pkg;

   // ascii code of 'a'
   localparam logic [6:0] LETTER_BASE = 7'd97;

   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_PATTERN = 2'd1,
      OP_RESTART = 2'd2,
      OP_TEXT    = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_PAT_WR,
      ST_RESTART,
      ST_WALK,
      ST_WALK_END,
      ST_OLD_RD,
      ST_OLD_WR,
      ST_NEW_RD,
      ST_NEW_WR,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/awm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module awm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/anagram_window_matcher.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  handshake            fields
// req      in   req_valid/req_stall  req_operation[1:0], req_character[6:0]
// rsp      out  rsp_valid/rsp_stall  rsp_match, rsp_start_index[31:0], rsp_pattern_overflow
//
// one word at a time; a full-window text letter runs ST_OLD_RD, ST_OLD_WR, ST_NEW_RD and
// ST_NEW_WR (read-modify-write of two difference-table entries), a filling one the last two.
// a restart or a pattern letter that no longer fits walks the table in ST_RESTART and
// ST_WALK, an added pattern letter after ST_PAT_WR; clear, ignored letters and text with no
// pattern go to ST_DONE. reset clears control state and table valid bits; a stalled rsp
// word is held while the next req is taken, and the word after it waits for it to leave.

module anagram_window_matcher
   import awm_pkg::*;
#(
   parameter int MAX_PATTERN   = 64,
   parameter int ALPHABET_SIZE = 26
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic [6:0]  req_character,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_match,
   output logic [31:0]      rsp_start_index,
   output logic             rsp_pattern_overflow
);

   localparam int LW   = $clog2(ALPHABET_SIZE);
   localparam int CW   = $clog2(MAX_PATTERN + 1);
   localparam int DW   = CW + 1;
   localparam int LENW = CW;
   localparam int PW   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int NZW  = $clog2(ALPHABET_SIZE + 1);

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic [LW-1:0]   letter_ff, letter_in;
   logic            lvalid_ff, lvalid_in;
   logic [ALPHABET_SIZE-1:0] pvalid_ff, pvalid_in;
   logic [ALPHABET_SIZE-1:0] dvalid_ff, dvalid_in;
   logic            pv_rd_ff, pv_rd_in;
   logic            dv_rd_ff, dv_rd_in;
   logic [NZW-1:0]  nz_ff, nz_in;
   logic [LENW-1:0] plen_ff, plen_in;
   logic [LENW-1:0] fill_ff, fill_in;
   logic [PW-1:0]   ptr_ff, ptr_in;
   logic [31:0]     pos_ff, pos_in;
   logic [LW-1:0]   walk_ff, walk_in;
   logic            pend_ff, pend_in;
   logic [LW-1:0]   waddr_ff, waddr_in;
   logic [LW-1:0]   old_ff, old_in;
   logic            res_match_ff, res_match_in;
   logic [31:0]     res_start_ff, res_start_in;
   logic            res_ovf_ff, res_ovf_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_match_ff, rsp_match_in;
   logic [31:0]     rsp_start_ff, rsp_start_in;
   logic            rsp_ovf_ff, rsp_ovf_in;

   logic            pat_we, pat_re;
   logic [LW-1:0]   pat_waddr, pat_raddr;
   logic [CW-1:0]   pat_wdata, pat_rdata;
   logic            diff_we, diff_re;
   logic [LW-1:0]   diff_waddr, diff_raddr;
   logic [DW-1:0]   diff_wdata, diff_rdata;
   logic            ring_we, ring_re;
   logic [LW-1:0]   ring_wdata, ring_rdata;

   logic [7:0]      char_idx;
   logic            char_ok;
   logic [CW-1:0]   pat_cur;
   logic [DW-1:0]   diff_cur, diff_upd;
   logic [NZW-1:0]  nz_upd;

   awm_ram #(.WIDTH(CW), .DEPTH(ALPHABET_SIZE)) u_pat_ram (
      .clock  (clock),
      .wr_en  (pat_we),
      .wr_addr(pat_waddr),
      .wr_data(pat_wdata),
      .rd_en  (pat_re),
      .rd_addr(pat_raddr),
      .rd_data(pat_rdata)
   );

   awm_ram #(.WIDTH(DW), .DEPTH(ALPHABET_SIZE)) u_diff_ram (
      .clock  (clock),
      .wr_en  (diff_we),
      .wr_addr(diff_waddr),
      .wr_data(diff_wdata),
      .rd_en  (diff_re),
      .rd_addr(diff_raddr),
      .rd_data(diff_rdata)
   );

   awm_ram #(.WIDTH(LW), .DEPTH(MAX_PATTERN)) u_ring_ram (
      .clock  (clock),
      .wr_en  (ring_we),
      .wr_addr(ptr_ff),
      .wr_data(ring_wdata),
      .rd_en  (ring_re),
      .rd_addr(ptr_ff),
      .rd_data(ring_rdata)
   );

   assign char_idx = {1'b0, req_character} - {1'b0, LETTER_BASE};
   assign char_ok  = (req_character >= LETTER_BASE) &&
                     ({1'b0, char_idx} < 9'(ALPHABET_SIZE));

   // entries never written since clear read as zero
   assign pat_cur  = pv_rd_ff ? pat_rdata : '0;
   assign diff_cur = dv_rd_ff ? diff_rdata : '0;

   assign req_stall            = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_match            = rsp_match_ff;
   assign rsp_start_index      = rsp_start_ff;
   assign rsp_pattern_overflow = rsp_ovf_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      letter_in    = letter_ff;
      lvalid_in    = lvalid_ff;
      pvalid_in    = pvalid_ff;
      dvalid_in    = dvalid_ff;
      pv_rd_in     = pv_rd_ff;
      dv_rd_in     = dv_rd_ff;
      nz_in        = nz_ff;
      plen_in      = plen_ff;
      fill_in      = fill_ff;
      ptr_in       = ptr_ff;
      pos_in       = pos_ff;
      walk_in      = walk_ff;
      pend_in      = pend_ff;
      waddr_in     = waddr_ff;
      old_in       = old_ff;
      res_match_in = res_match_ff;
      res_start_in = res_start_ff;
      res_ovf_in   = res_ovf_ff;
      rsp_match_in = rsp_match_ff;
      rsp_start_in = rsp_start_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      pat_we     = 1'b0;
      pat_waddr  = letter_ff;
      pat_wdata  = pat_cur + CW'(1);
      pat_re     = 1'b0;
      pat_raddr  = letter_ff;
      diff_we    = 1'b0;
      diff_waddr = letter_ff;
      diff_wdata = diff_cur;
      diff_re    = 1'b0;
      diff_raddr = letter_ff;
      ring_we    = 1'b0;
      ring_re    = 1'b0;
      ring_wdata = letter_ff;
      diff_upd   = diff_cur;
      nz_upd     = nz_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in     = op_type'(req_operation);
               letter_in = LW'(char_idx);
               lvalid_in = char_ok;
               state_in  = ST_DECODE;
            end
         end

         ST_DECODE: begin
            res_match_in = 1'b0;
            res_start_in = '0;
            res_ovf_in   = 1'b0;
            state_in     = ST_DONE;
            unique case (op_ff)
               OP_CLEAR: begin
                  pvalid_in = '0;
                  dvalid_in = '0;
                  nz_in     = '0;
                  plen_in   = '0;
                  fill_in   = '0;
                  ptr_in    = '0;
                  pos_in    = '0;
               end
               OP_PATTERN: begin
                  if (lvalid_ff) begin
                     if (plen_ff < LENW'(MAX_PATTERN)) begin
                        pat_re   = 1'b1;
                        pv_rd_in = pvalid_ff[letter_ff];
                        state_in = ST_PAT_WR;
                     end else begin
                        res_ovf_in = 1'b1;
                        state_in   = ST_RESTART;
                     end
                  end
               end
               OP_RESTART: begin
                  state_in = ST_RESTART;
               end
               OP_TEXT: begin
                  if (lvalid_ff) begin
                     if (plen_ff == '0) begin
                        pos_in = pos_ff + 32'd1;
                     end else if (fill_ff >= plen_ff) begin
                        ring_re  = 1'b1;
                        state_in = ST_OLD_RD;
                     end else begin
                        fill_in  = fill_ff + LENW'(1);
                        state_in = ST_NEW_RD;
                     end
                  end
               end
               default: ;
            endcase
         end

         ST_PAT_WR: begin
            pat_we               = 1'b1;
            pvalid_in[letter_ff] = 1'b1;
            plen_in              = plen_ff + LENW'(1);
            state_in             = ST_RESTART;
         end

         ST_RESTART: begin
            nz_in    = '0;
            fill_in  = '0;
            ptr_in   = '0;
            pos_in   = '0;
            walk_in  = '0;
            pend_in  = 1'b0;
            state_in = ST_WALK;
         end

         ST_WALK, ST_WALK_END: begin
            // copy the pattern histogram, one entry read while the previous one is written
            if (pend_ff) begin
               diff_we             = 1'b1;
               diff_waddr          = waddr_ff;
               diff_wdata          = DW'(pat_cur);
               dvalid_in[waddr_ff] = 1'b1;
               if (pat_cur != '0) begin
                  nz_in = nz_ff + NZW'(1);
               end
            end
            if (state_ff == ST_WALK) begin
               pat_re    = 1'b1;
               pat_raddr = walk_ff;
               pv_rd_in  = pvalid_ff[walk_ff];
               pend_in   = 1'b1;
               waddr_in  = walk_ff;
               walk_in   = walk_ff + LW'(1);
               if (walk_ff == LW'(ALPHABET_SIZE - 1)) begin
                  state_in = ST_WALK_END;
               end
            end else begin
               pend_in  = 1'b0;
               state_in = ST_DONE;
            end
         end

         ST_OLD_RD: begin
            old_in = ring_rdata;
            if ({1'b0, ring_rdata} < (LW + 1)'(ALPHABET_SIZE)) begin
               diff_re    = 1'b1;
               diff_raddr = ring_rdata;
               dv_rd_in   = dvalid_ff[ring_rdata];
               state_in   = ST_OLD_WR;
            end else begin
               state_in = ST_NEW_RD;
            end
         end

         ST_OLD_WR, ST_NEW_WR: begin
            // outgoing letter adds one, incoming letter takes one away
            if (state_ff == ST_OLD_WR) begin
               diff_upd   = diff_cur + DW'(1);
               diff_waddr = old_ff;
            end else begin
               diff_upd   = diff_cur - DW'(1);
               diff_waddr = letter_ff;
            end
            diff_we                = 1'b1;
            diff_wdata             = diff_upd;
            dvalid_in[diff_waddr]  = 1'b1;
            if (diff_cur == '0 && diff_upd != '0) begin
               nz_upd = nz_ff + NZW'(1);
            end else if (diff_cur != '0 && diff_upd == '0) begin
               nz_upd = nz_ff - NZW'(1);
            end
            nz_in = nz_upd;
            if (state_ff == ST_OLD_WR) begin
               state_in = ST_NEW_RD;
            end else begin
               if (fill_ff >= plen_ff && nz_upd == '0) begin
                  res_match_in = 1'b1;
                  res_start_in = pos_ff - 32'(plen_ff) + 32'd1;
               end
               pos_in   = pos_ff + 32'd1;
               state_in = ST_DONE;
            end
         end

         ST_NEW_RD: begin
            diff_re  = 1'b1;
            dv_rd_in = dvalid_ff[letter_ff];
            ring_we  = 1'b1;
            if (LENW'(ptr_ff) + LENW'(1) >= plen_ff) begin
               ptr_in = '0;
            end else begin
               ptr_in = ptr_ff + PW'(1);
            end
            state_in = ST_NEW_WR;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_match_in = res_match_ff;
               rsp_start_in = res_start_ff;
               rsp_ovf_in   = res_ovf_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pvalid_ff    <= '0;
         dvalid_ff    <= '0;
         nz_ff        <= '0;
         plen_ff      <= '0;
         fill_ff      <= '0;
         ptr_ff       <= '0;
         pos_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pvalid_ff    <= pvalid_in;
         dvalid_ff    <= dvalid_in;
         nz_ff        <= nz_in;
         plen_ff      <= plen_in;
         fill_ff      <= fill_in;
         ptr_ff       <= ptr_in;
         pos_ff       <= pos_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      letter_ff    <= letter_in;
      lvalid_ff    <= lvalid_in;
      pv_rd_ff     <= pv_rd_in;
      dv_rd_ff     <= dv_rd_in;
      walk_ff      <= walk_in;
      waddr_ff     <= waddr_in;
      old_ff       <= old_in;
      res_match_ff <= res_match_in;
      res_start_ff <= res_start_in;
      res_ovf_ff   <= res_ovf_in;
      rsp_match_ff <= rsp_match_in;
      rsp_start_ff <= rsp_start_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

endmodule

`default_nettype wire
